[design/lci_pkg.sv]
// ----------------------------------------------------------------------------
// lci_pkg: shared widths, codes and types
// Widths cover every fraction-bit setting from 4 to 16.
// ----------------------------------------------------------------------------
package lci_pkg;

  localparam int AW       = 34;  // a = s^2 + m^2
  localparam int HW       = 34;  // h = cx*s - m*d
  localparam int EW       = 34;  // e = d*s + m*cx
  localparam int DW       = 64;  // discriminant
  localparam int RW       = 48;  // square root
  localparam int REMW     = 52;  // square root remainder
  localparam int NW       = 52;  // doubled, offset numerator
  localparam int QW       = 51;  // numerator magnitude and raw quotient
  localparam int DVW      = 34;  // divisor 2*a
  localparam int UW       = 44;  // rounded x before saturation
  localparam int ULO      = 22;  // low slice of x for the split multiply
  localparam int PW       = 60;  // slope * x product
  localparam int SQ_STEPS = 48;

  localparam logic [1:0] CNT_NONE    = 2'd0;
  localparam logic [1:0] CNT_TANGENT = 2'd1;
  localparam logic [1:0] CNT_SECANT  = 2'd2;

  typedef struct packed {
    logic [1:0]           cnt;
    logic signed [HW-1:0] h;
    logic [AW-1:0]        a;
    logic signed [15:0]   m;
    logic signed [15:0]   q;
  } lci_side_t;

  typedef struct packed {
    logic [1:0]         cnt;
    logic signed [15:0] m;
    logic signed [15:0] q;
  } lci_tail_t;

endpackage

[design/lci_front.sv]
// ----------------------------------------------------------------------------
// lci_front: quadratic coefficients and exact discriminant
// Five register stages: products, coefficients, squares, sum, compare.
// ----------------------------------------------------------------------------
module lci_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic signed [15:0]         slope,
  input  logic signed [15:0]         intercept,
  input  logic signed [15:0]         cx,
  input  logic signed [15:0]         cy,
  input  logic [14:0]                radius,
  output logic                       out_valid,
  output lci_pkg::lci_side_t         side,
  output logic [lci_pkg::DW-1:0]     disc
);

  localparam int AW = lci_pkg::AW;
  localparam int HW = lci_pkg::HW;
  localparam int EW = lci_pkg::EW;
  localparam int DW = lci_pkg::DW;
  localparam logic [AW-1:0] S_SQ = AW'(1) << (2 * FRAC_BITS);

  // stage 1
  logic signed [16:0] d_nxt;
  logic signed [31:0] mm_nxt;
  logic signed [32:0] md_nxt;
  logic signed [31:0] mcx_nxt;
  logic [29:0]        r2_nxt;
  logic               v1_r;
  logic signed [15:0] m1_r, q1_r, cx1_r;
  logic signed [16:0] d1_r;
  logic [30:0]        mm1_r;
  logic signed [32:0] md1_r;
  logic signed [31:0] mcx1_r;
  logic [29:0]        r21_r;

  assign d_nxt   = 17'(intercept) - 17'(cy);
  assign mm_nxt  = slope * slope;
  assign md_nxt  = slope * d_nxt;
  assign mcx_nxt = slope * cx;
  assign r2_nxt  = radius * radius;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r   <= slope;
      q1_r   <= intercept;
      cx1_r  <= cx;
      d1_r   <= d_nxt;
      mm1_r  <= mm_nxt[30:0];
      md1_r  <= md_nxt;
      mcx1_r <= mcx_nxt;
      r21_r  <= r2_nxt;
    end
  end

  // stage 2
  logic [AW-1:0]        a_nxt;
  logic signed [HW-1:0] h_nxt;
  logic signed [EW-1:0] e_nxt;
  logic [EW-1:0]        ae_nxt;
  logic                 v2_r, big2_r;
  logic [AW-1:0]        a2_r;
  logic signed [HW-1:0] h2_r;
  logic [31:0]          ae2_r;
  logic [29:0]          r22_r;
  logic signed [15:0]   m2_r, q2_r;

  assign a_nxt  = S_SQ + AW'(mm1_r);
  assign h_nxt  = (HW'(cx1_r) <<< FRAC_BITS) - HW'(md1_r);
  assign e_nxt  = (EW'(d1_r) <<< FRAC_BITS) + EW'(mcx1_r);
  assign ae_nxt = e_nxt[EW-1] ? EW'(-e_nxt) : EW'(e_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r   <= a_nxt;
      h2_r   <= h_nxt;
      ae2_r  <= ae_nxt[31:0];
      big2_r <= |ae_nxt[EW-1:32];
      r22_r  <= r21_r;
      m2_r   <= m1_r;
      q2_r   <= q1_r;
    end
  end

  // stage 3: a*r^2 in two slices, e^2
  logic [46:0]          plo_nxt, phi_nxt;
  logic [63:0]          esq_nxt;
  logic                 v3_r, big3_r;
  logic [46:0]          plo3_r, phi3_r;
  logic [63:0]          esq3_r;
  logic [AW-1:0]        a3_r;
  logic signed [HW-1:0] h3_r;
  logic signed [15:0]   m3_r, q3_r;

  assign plo_nxt = a2_r[16:0] * r22_r;
  assign phi_nxt = a2_r[AW-1:17] * r22_r;
  assign esq_nxt = ae2_r * ae2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plo3_r <= plo_nxt;
      phi3_r <= phi_nxt;
      esq3_r <= esq_nxt;
      big3_r <= big2_r;
      a3_r   <= a2_r;
      h3_r   <= h2_r;
      m3_r   <= m2_r;
      q3_r   <= q2_r;
    end
  end

  // stage 4
  logic [63:0]          ar2_nxt;
  logic                 v4_r, big4_r;
  logic [63:0]          ar24_r, esq4_r;
  logic [AW-1:0]        a4_r;
  logic signed [HW-1:0] h4_r;
  logic signed [15:0]   m4_r, q4_r;

  assign ar2_nxt = ({17'b0, phi3_r} << 17) + {17'b0, plo3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ar24_r <= ar2_nxt;
      esq4_r <= esq3_r;
      big4_r <= big3_r;
      a4_r   <= a3_r;
      h4_r   <= h3_r;
      m4_r   <= m3_r;
      q4_r   <= q3_r;
    end
  end

  // stage 5: the sign of the discriminant, and whether it is zero, decide the point count
  logic                 ok_w;
  logic [63:0]          diff_w;
  logic [DW-1:0]        disc_nxt;
  logic [1:0]           cnt_nxt;
  logic                 v5_r;
  logic [DW-1:0]        disc5_r;
  lci_pkg::lci_side_t   side5_r;

  always_comb begin
    ok_w     = !big4_r && (ar24_r >= esq4_r);
    diff_w   = ar24_r - esq4_r;
    disc_nxt = ok_w ? DW'(diff_w) : '0;
    if (!ok_w) begin
      cnt_nxt = lci_pkg::CNT_NONE;
    end else if (diff_w != 64'd0) begin
      cnt_nxt = lci_pkg::CNT_SECANT;
    end else begin
      cnt_nxt = lci_pkg::CNT_TANGENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      disc5_r     <= disc_nxt;
      side5_r.cnt <= cnt_nxt;
      side5_r.h   <= h4_r;
      side5_r.a   <= a4_r;
      side5_r.m   <= m4_r;
      side5_r.q   <= q4_r;
    end
  end

  assign out_valid = v5_r;
  assign side      = side5_r;
  assign disc      = disc5_r;

endmodule

[design/lci_sqrt.sv]
// ----------------------------------------------------------------------------
// lci_sqrt: pipelined square root, one result bit per stage
// Returns floor(sqrt(disc * 2^32)); the low 32 input bits are implied zero.
// ----------------------------------------------------------------------------
module lci_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  lci_pkg::lci_side_t          side_in,
  input  logic [lci_pkg::DW-1:0]      disc_in,
  output logic                        out_valid,
  output lci_pkg::lci_side_t          side_out,
  output logic [lci_pkg::RW-1:0]      root_out
);

  localparam int N    = lci_pkg::SQ_STEPS;
  localparam int DW   = lci_pkg::DW;
  localparam int RW   = lci_pkg::RW;
  localparam int REMW = lci_pkg::REMW;

  logic               v_r    [0:N-1];
  lci_pkg::lci_side_t side_r [0:N-1];
  logic [DW-1:0]      disc_r [0:N-1];
  logic [RW-1:0]      root_r [0:N-1];
  logic [REMW-1:0]    rem_r  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic               v_k;
    lci_pkg::lci_side_t side_k;
    logic [DW-1:0]      disc_k;
    logic [RW-1:0]      root_k;
    logic [REMW-1:0]    rem_k;
    logic [REMW-1:0]    rem_sh, trial;
    logic               take;

    if (k == 0) begin : g_head
      assign v_k    = in_valid;
      assign side_k = side_in;
      assign disc_k = disc_in;
      assign root_k = '0;
      assign rem_k  = '0;
    end else begin : g_link
      assign v_k    = v_r[k-1];
      assign side_k = side_r[k-1];
      assign disc_k = disc_r[k-1];
      assign root_k = root_r[k-1];
      assign rem_k  = rem_r[k-1];
    end

    // The discriminant shifts up two bits a stage, so its top pair is the next digit.
    always_comb begin
      rem_sh = {rem_k[REMW-3:0], disc_k[DW-1 -: 2]};
      trial  = {{(REMW-RW-2){1'b0}}, root_k, 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_k;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k] <= side_k;
        disc_r[k] <= disc_k << 2;
        rem_r[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_k[RW-2:0], take};
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign side_out  = side_r[N-1];
  assign root_out  = root_r[N-1];

endmodule

[design/lci_div.sv]
// ----------------------------------------------------------------------------
// lci_div: two-lane pipelined divider for the rounded roots
// x = floor((2*(h*2^16 -/+ sq) + a) / (2*a)), one quotient bit per stage.
// ----------------------------------------------------------------------------
module lci_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  lci_pkg::lci_side_t             side_in,
  input  logic [lci_pkg::RW-1:0]         root_in,
  output logic                           out_valid,
  output lci_pkg::lci_tail_t             tail_out,
  output logic signed [lci_pkg::UW-1:0]  u_first,
  output logic signed [lci_pkg::UW-1:0]  u_second
);

  localparam int AW  = lci_pkg::AW;
  localparam int HW  = lci_pkg::HW;
  localparam int RW  = lci_pkg::RW;
  localparam int NW  = lci_pkg::NW;
  localparam int QW  = lci_pkg::QW;
  localparam int DVW = lci_pkg::DVW;
  localparam int UW  = lci_pkg::UW;
  localparam int N1W = HW + 17;

  lci_pkg::lci_tail_t tail_in;
  assign tail_in.cnt = side_in.cnt;
  assign tail_in.m   = side_in.m;
  assign tail_in.q   = side_in.q;

  // P1: h*2^16 minus and plus the root
  logic signed [N1W-1:0] base_w, sq_w;
  logic                  v_p1_r;
  logic signed [N1W-1:0] n_p1_r [0:1];
  logic [AW-1:0]         a_p1_r;
  lci_pkg::lci_tail_t    tail_p1_r;

  assign base_w = {side_in.h[HW-1], side_in.h, 16'b0};
  assign sq_w   = {{(N1W-RW){1'b0}}, root_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p1_r <= 1'b0;
    end else if (adv) begin
      v_p1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_p1_r[0] <= base_w - sq_w;
      n_p1_r[1] <= base_w + sq_w;
      a_p1_r    <= side_in.a;
      tail_p1_r <= tail_in;
    end
  end

  // P2: doubled numerator plus a, for round half up
  logic               v_p2_r;
  logic [NW-1:0]      num_p2_r [0:1];
  logic [AW-1:0]      a_p2_r;
  lci_pkg::lci_tail_t tail_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p2_r <= 1'b0;
    end else if (adv) begin
      v_p2_r <= v_p1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_p2_r[0] <= {n_p1_r[0], 1'b0} + {{(NW-AW){1'b0}}, a_p1_r};
      num_p2_r[1] <= {n_p1_r[1], 1'b0} + {{(NW-AW){1'b0}}, a_p1_r};
      a_p2_r      <= a_p1_r;
      tail_p2_r   <= tail_p1_r;
    end
  end

  // P3: sign and magnitude; the divisor 2*a
  logic [NW-1:0]      negn_w [0:1];
  logic               v_p3_r;
  logic [QW-1:0]      mag_p3_r [0:1];
  logic               neg_p3_r [0:1];
  logic [DVW-1:0]     dvs_p3_r;
  lci_pkg::lci_tail_t tail_p3_r;

  assign negn_w[0] = '0 - num_p2_r[0];
  assign negn_w[1] = '0 - num_p2_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p3_r <= 1'b0;
    end else if (adv) begin
      v_p3_r <= v_p2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        neg_p3_r[l] <= num_p2_r[l][NW-1];
        mag_p3_r[l] <= num_p2_r[l][NW-1] ? negn_w[l][QW-1:0] : num_p2_r[l][QW-1:0];
      end
      dvs_p3_r  <= {a_p2_r[DVW-2:0], 1'b0};
      tail_p3_r <= tail_p2_r;
    end
  end

  // restoring division, one bit a stage
  logic               v_d_r    [0:QW-1];
  lci_pkg::lci_tail_t tail_d_r [0:QW-1];
  logic [DVW-1:0]     dvs_d_r  [0:QW-1];
  logic               neg_d_r  [0:QW-1][0:1];
  logic [QW-1:0]      mag_d_r  [0:QW-1][0:1];
  logic [QW-1:0]      quo_d_r  [0:QW-1][0:1];
  logic [DVW-1:0]     rem_d_r  [0:QW-1][0:1];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic               v_k;
    lci_pkg::lci_tail_t tail_k;
    logic [DVW-1:0]     dvs_k;

    if (k == 0) begin : g_head
      assign v_k    = v_p3_r;
      assign tail_k = tail_p3_r;
      assign dvs_k  = dvs_p3_r;
    end else begin : g_link
      assign v_k    = v_d_r[k-1];
      assign tail_k = tail_d_r[k-1];
      assign dvs_k  = dvs_d_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_d_r[k] <= 1'b0;
      end else if (adv) begin
        v_d_r[k] <= v_k;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tail_d_r[k] <= tail_k;
        dvs_d_r[k]  <= dvs_k;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic             neg_k;
      logic [QW-1:0]    mag_k, quo_k;
      logic [DVW-1:0]   rem_k;
      logic [DVW:0]     rsh, dif;
      logic             take;

      if (k == 0) begin : g_head
        assign neg_k = neg_p3_r[l];
        assign mag_k = mag_p3_r[l];
        assign quo_k = '0;
        assign rem_k = '0;
      end else begin : g_link
        assign neg_k = neg_d_r[k-1][l];
        assign mag_k = mag_d_r[k-1][l];
        assign quo_k = quo_d_r[k-1][l];
        assign rem_k = rem_d_r[k-1][l];
      end

      always_comb begin
        rsh  = {rem_k, mag_k[QW-1]};
        dif  = rsh - {1'b0, dvs_k};
        take = rsh >= {1'b0, dvs_k};
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          neg_d_r[k][l] <= neg_k;
          mag_d_r[k][l] <= mag_k << 1;
          quo_d_r[k][l] <= {quo_k[QW-2:0], take};
          rem_d_r[k][l] <= take ? dif[DVW-1:0] : rsh[DVW-1:0];
        end
      end
    end
  end

  // floor for a negative numerator: -(q + 1) when the remainder is not zero
  logic [QW-1:0]      qadj_w [0:1];
  logic [QW-1:0]      qsgn_w [0:1];
  logic               v_f_r;
  logic signed [UW-1:0] u_f_r [0:1];
  lci_pkg::lci_tail_t tail_f_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qadj_w[l] = quo_d_r[QW-1][l] + {{(QW-1){1'b0}}, |rem_d_r[QW-1][l]};
      qsgn_w[l] = neg_d_r[QW-1][l] ? ('0 - qadj_w[l]) : quo_d_r[QW-1][l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (adv) begin
      v_f_r <= v_d_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_f_r[0] <= $signed(qsgn_w[0][UW-1:0]);
      u_f_r[1] <= $signed(qsgn_w[1][UW-1:0]);
      tail_f_r <= tail_d_r[QW-1];
    end
  end

  assign out_valid = v_f_r;
  assign tail_out  = tail_f_r;
  assign u_first   = u_f_r[0];
  assign u_second  = u_f_r[1];

endmodule

[design/lci_back.sv]
// ----------------------------------------------------------------------------
// lci_back: y from x, saturation, and the output register
// Four stages: split multiply, product sum, rounding, offset and clamp.
// ----------------------------------------------------------------------------
module lci_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  lci_pkg::lci_tail_t             tail_in,
  input  logic signed [lci_pkg::UW-1:0]  u_first,
  input  logic signed [lci_pkg::UW-1:0]  u_second,
  output logic                           out_valid,
  output logic [1:0]                     point_count,
  output logic signed [31:0]             first_x,
  output logic signed [31:0]             first_y,
  output logic signed [31:0]             second_x,
  output logic signed [31:0]             second_y
);

  localparam int UW  = lci_pkg::UW;
  localparam int ULO = lci_pkg::ULO;
  localparam int PW  = lci_pkg::PW;
  localparam int LW  = 16 + ULO + 1;
  localparam int HHW = 16 + UW - ULO;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

  function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
    logic [31:0] res;
    if ((&v[PW-1:31]) || !(|v[PW-1:31])) begin
      res = v[31:0];
    end else if (v[PW-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7fff_ffff;
    end
    return res;
  endfunction

  logic signed [UW-1:0] u_w [0:1];
  assign u_w[0] = u_first;
  assign u_w[1] = u_second;

  // B1
  logic signed [LW-1:0]  pl_nxt [0:1];
  logic signed [HHW-1:0] ph_nxt [0:1];
  logic                  v1_r;
  logic signed [LW-1:0]  pl1_r [0:1];
  logic signed [HHW-1:0] ph1_r [0:1];
  logic signed [UW-1:0]  u1_r  [0:1];
  lci_pkg::lci_tail_t    tail1_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pl_nxt[l] = tail_in.m * $signed({1'b0, u_w[l][ULO-1:0]});
      ph_nxt[l] = tail_in.m * $signed(u_w[l][UW-1:ULO]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl1_r   <= pl_nxt;
      ph1_r   <= ph_nxt;
      u1_r    <= u_w;
      tail1_r <= tail_in;
    end
  end

  // B2
  logic                 v2_r;
  logic signed [PW-1:0] prod2_r [0:1];
  logic signed [UW-1:0] u2_r    [0:1];
  lci_pkg::lci_tail_t   tail2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        prod2_r[l] <= (PW'(ph1_r[l]) <<< ULO) + PW'(pl1_r[l]);
      end
      u2_r    <= u1_r;
      tail2_r <= tail1_r;
    end
  end

  // B3: round half up to Q16.16
  logic                 v3_r;
  logic signed [PW-1:0] t3_r [0:1];
  logic signed [UW-1:0] u3_r [0:1];
  lci_pkg::lci_tail_t   tail3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        t3_r[l] <= (prod2_r[l] + HALF) >>> FRAC_BITS;
      end
      u3_r    <= u2_r;
      tail3_r <= tail2_r;
    end
  end

  // B4: output register
  logic signed [PW-1:0] qy_w;
  logic signed [PW-1:0] y_w [0:1];
  logic                 none_w;
  logic                 v4_r;
  logic [1:0]           cnt4_r;
  logic [31:0]          x4_r [0:1];
  logic [31:0]          y4_r [0:1];

  always_comb begin
    qy_w   = PW'(tail3_r.q) <<< (16 - FRAC_BITS);
    none_w = tail3_r.cnt == lci_pkg::CNT_NONE;
    for (int l = 0; l < 2; l++) begin
      y_w[l] = qy_w + t3_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt4_r <= tail3_r.cnt;
      for (int l = 0; l < 2; l++) begin
        x4_r[l] <= none_w ? 32'd0 : sat32(PW'(u3_r[l]));
        y4_r[l] <= none_w ? 32'd0 : sat32(y_w[l]);
      end
    end
  end

  assign out_valid   = v4_r;
  assign point_count = cnt4_r;
  assign first_x     = $signed(x4_r[0]);
  assign first_y     = $signed(y4_r[0]);
  assign second_x    = $signed(x4_r[1]);
  assign second_y    = $signed(y4_r[1]);

endmodule

[design/line_circle_intersection.sv]
// ----------------------------------------------------------------------------
// line_circle_intersection: line / circle crossing points
// Solves the line-in-circle quadratic exactly and returns 0, 1 or 2 points.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_ready    | slope, intercept, center x/y (Q8.8), radius
//  out     | out_valid / out_ready  | point count, two points (Q16.16)
//
// One beat is accepted per cycle while no result waits at the output; the 48-stage
// square root and the 51-stage divide loop make up most of the pipeline in the middle.
// Reset clears only the valid bits of every stage.
// When a result waits at the output, every stage holds together and in_ready
// drops; nothing is lost or repeated.
module line_circle_intersection #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_line_slope,
  input  logic signed [15:0] in_line_intercept,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic [14:0]        in_circle_radius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_point_count,
  output logic signed [31:0] out_first_x,
  output logic signed [31:0] out_first_y,
  output logic signed [31:0] out_second_x,
  output logic signed [31:0] out_second_y
);

  logic adv;

  logic                         fr_valid;
  lci_pkg::lci_side_t           fr_side;
  logic [lci_pkg::DW-1:0]       fr_disc;

  logic                         sq_valid;
  lci_pkg::lci_side_t           sq_side;
  logic [lci_pkg::RW-1:0]       sq_root;

  logic                         dv_valid;
  lci_pkg::lci_tail_t           dv_tail;
  logic signed [lci_pkg::UW-1:0] dv_u_first, dv_u_second;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  lci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .slope     (in_line_slope),
    .intercept (in_line_intercept),
    .cx        (in_center_x),
    .cy        (in_center_y),
    .radius    (in_circle_radius),
    .out_valid (fr_valid),
    .side      (fr_side),
    .disc      (fr_disc)
  );

  lci_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .side_in   (fr_side),
    .disc_in   (fr_disc),
    .out_valid (sq_valid),
    .side_out  (sq_side),
    .root_out  (sq_root)
  );

  lci_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (sq_valid),
    .side_in   (sq_side),
    .root_in   (sq_root),
    .out_valid (dv_valid),
    .tail_out  (dv_tail),
    .u_first   (dv_u_first),
    .u_second  (dv_u_second)
  );

  lci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (dv_valid),
    .tail_in     (dv_tail),
    .u_first     (dv_u_first),
    .u_second    (dv_u_second),
    .out_valid   (out_valid),
    .point_count (out_point_count),
    .first_x     (out_first_x),
    .first_y     (out_first_y),
    .second_x    (out_second_x),
    .second_y    (out_second_y)
  );

endmodule

[design/lci_chk.sv]
// ----------------------------------------------------------------------------
// lci_chk: port-level checks for line_circle_intersection
// Watches the result channel and the consistency of the reported points.
// ----------------------------------------------------------------------------
module lci_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_point_count,
  input logic signed [31:0] out_first_x,
  input logic signed [31:0] out_first_y,
  input logic signed [31:0] out_second_x,
  input logic signed [31:0] out_second_y
);

  // A stalled result beat keeps its point count and its x coordinates.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_first_x) &&
      $stable(out_second_x) && $stable(out_point_count))
    else $error("result beat changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_count == lci_pkg::CNT_NONE |->
      out_first_x == 0 && out_first_y == 0 && out_second_x == 0 && out_second_y == 0)
    else $error("no intersection but nonzero point");

  a_tangent_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_count == lci_pkg::CNT_TANGENT |->
      out_first_x == out_second_x && out_first_y == out_second_y)
    else $error("tangent points differ");

  a_secant_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_count == lci_pkg::CNT_SECANT |-> out_first_x <= out_second_x)
    else $error("roots out of order");

  // The input side is stalled exactly when a result is held.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

endmodule

bind line_circle_intersection lci_chk u_lci_chk (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: line / circle intersection testbench
// A directed table is followed by random queries. The in channel is driven in
// bursts and the out channel stalls on its own pattern, with one long hold-off.
// Every result beat is checked against typed values or a local model of the exact arithmetic.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC      = 8;
  localparam int N_RANDOM  = 1500;
  localparam int IDLE_MAX  = 3000;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_LEN = 130;

  typedef struct {
    logic signed [15:0] slope;
    logic signed [15:0] icpt;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        rad;
  } query_t;

  typedef struct {
    logic [1:0]         cnt;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
  } points_t;

  typedef struct {
    query_t  q;
    bit      typed;
    points_t pts;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_line_slope;
  logic signed [15:0] in_line_intercept;
  logic signed [15:0] in_center_x;
  logic signed [15:0] in_center_y;
  logic [14:0] in_circle_radius;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_point_count;
  logic signed [31:0] out_first_x;
  logic signed [31:0] out_first_y;
  logic signed [31:0] out_second_x;
  logic signed [31:0] out_second_y;

  points_t pending_points[$];
  int errors = 0;
  int n_results = 0;
  int n_tangent = 0;
  int n_secant = 0;
  int idle_cycles = 0;
  bit in_beat;
  bit out_beat;
  bit hold_request = 0;

  line_circle_intersection #(.FRAC_BITS(FRAC)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint floor_quot(longint n, longint d);
    longint qt;
    qt = n / d;
    if ((n % d) != 0 && n < 0) qt -= 1;
    return qt;
  endfunction

  function automatic longint round_quot(longint n, longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(sqrt(v * 2^32)), two bits of the radicand per step
  function automatic longint scaled_root(logic [63:0] v);
    logic [127:0] rad;
    logic [127:0] root;
    logic [127:0] rem;
    logic [127:0] trial;
    rad = {v, 32'b0};
    root = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | rad[2*i+1 -: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root[63:0]);
  endfunction

  function automatic points_t solve_crossing(query_t qi);
    points_t p;
    longint s, m, q, cx, cy, r, d, a, h, e, sq, base, qy, u1, u2;
    logic [63:0] ae, ar2, disc;
    s = longint'(1) << FRAC;
    m = longint'(qi.slope);
    q = longint'(qi.icpt);
    cx = longint'(qi.cx);
    cy = longint'(qi.cy);
    r = longint'({1'b0, qi.rad});
    d = q - cy;
    a = s * s + m * m;
    h = cx * s - m * d;
    e = d * s + m * cx;
    ae = (e < 0) ? -e : e;
    ar2 = a * (r * r);
    p = '{lci_pkg::CNT_NONE, 0, 0, 0, 0};
    disc = 0;
    if (ae < 64'h1_0000_0000 && ae * ae <= ar2) begin
      disc = ar2 - ae * ae;
      p.cnt = (disc != 0) ? lci_pkg::CNT_SECANT : lci_pkg::CNT_TANGENT;
    end
    if (p.cnt != lci_pkg::CNT_NONE) begin
      sq = scaled_root(disc);
      base = h * 65536;
      qy = q * (longint'(1) << (16 - FRAC));
      u1 = round_quot(base - sq, a);
      u2 = round_quot(base + sq, a);
      p.y1 = 32'(clamp32(qy + round_quot(m * u1, s)));
      p.y2 = 32'(clamp32(qy + round_quot(m * u2, s)));
      p.x1 = 32'(clamp32(u1));
      p.x2 = 32'(clamp32(u2));
    end
    return p;
  endfunction

  function automatic query_t random_query();
    query_t qi;
    int kind;
    kind = $urandom_range(0, 3);
    qi.slope = 16'($urandom);
    qi.icpt = 16'($urandom);
    qi.cx = 16'($urandom);
    qi.cy = 16'($urandom);
    qi.rad = 15'($urandom);
    case (kind)
      1: begin
        // Modest geometry with a large circle, so most lines cross it.
        qi.slope = 16'($signed($urandom_range(0, 2047)) - 1024);
        qi.cx = 16'($signed($urandom_range(0, 4095)) - 2048);
        qi.cy = 16'($signed($urandom_range(0, 4095)) - 2048);
        qi.icpt = qi.cy + 16'($signed($urandom_range(0, 1023)) - 512);
        qi.rad = 15'($urandom_range(4096, 32767));
      end
      2: begin
        // Zero radius: the line either hits the center exactly or misses.
        qi.rad = 0;
        qi.cx = ($urandom_range(0, 1) != 0) ? 16'sd0 : qi.cx;
        qi.slope = ($urandom_range(0, 1) != 0) ? 16'sd0 : qi.slope;
        if ($urandom_range(0, 3) != 0) qi.icpt = qi.cy;
      end
      3: begin
        // Horizontal line at distance equal to the radius touches the circle.
        qi.slope = 0;
        qi.rad = 15'($urandom_range(0, 16383));
        qi.icpt = qi.cy + (($urandom_range(0, 1) != 0) ? $signed({1'b0, qi.rad})
                                                       : -$signed({1'b0, qi.rad}));
      end
      default: ;
    endcase
    return qi;
  endfunction

  // Expected values are typed in only where they follow directly.
  row_t directed[$] = '{
    '{'{16'sd0, 16'sd256, 16'sd0, 16'sd0, 15'd0}, 1,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd0}, 1,
      '{lci_pkg::CNT_TANGENT, 0, 0, 0, 0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd256}, 1,
      '{lci_pkg::CNT_SECANT, -32'sd65536, 32'sd0, 32'sd65536, 32'sd0}},
    '{'{16'sd0, 16'sd256, 16'sd0, 16'sd0, 15'd256}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd256, 16'sd0, 16'sd0, 16'sd0, 15'd256}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd0, -16'sd32768, 16'sd0, -16'sd32768, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd0, 16'sd32767, 16'sd32767, 16'sd0, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd1, 16'sd0, -16'sd32768, 16'sd0, 15'd32767}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{-16'sd1, 16'sd100, 16'sd300, -16'sd50, 15'd1}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd0, 16'sd512, 16'sd1000, 16'sd0, 15'd512}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd128, 16'sd64, -16'sd700, 16'sd300, 15'd4000}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd1}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}},
    '{'{16'sd0, 16'sd300, 16'sd77, 16'sd300, 15'd0}, 0,
      '{lci_pkg::CNT_NONE, 0, 0, 0, 0}}
  };

  // Receiver: random stretches of ready patterns, plus one long hold-off.
  initial begin
    int mode, len;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        for (int i = 0; i < HOLD_LEN; i++) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(5, 60);
      for (int i = 0; i < len; i++) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) != 0);
          2: out_ready <= (i % 3 != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    in_beat = in_valid && in_ready && rst_n;
    out_beat = out_valid && out_ready && rst_n;
    if (in_beat || out_beat || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, IDLE_MAX);
      $display("simulation failed");
      $finish;
    end
    if (out_beat) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, got cnt=%0d", $time, out_point_count);
      end else begin
        points_t ex;
        ex = pending_points.pop_front();
        n_results++;
        if (ex.cnt == lci_pkg::CNT_TANGENT) n_tangent++;
        if (ex.cnt == lci_pkg::CNT_SECANT) n_secant++;
        if (out_point_count !== ex.cnt) begin
          errors++;
          $display("%0t: point_count expected %0d got %0d", $time, ex.cnt, out_point_count);
        end
        if (out_first_x !== ex.x1) begin
          errors++;
          $display("%0t: first_x expected %0d got %0d", $time, ex.x1, out_first_x);
        end
        if (out_first_y !== ex.y1) begin
          errors++;
          $display("%0t: first_y expected %0d got %0d", $time, ex.y1, out_first_y);
        end
        if (out_second_x !== ex.x2) begin
          errors++;
          $display("%0t: second_x expected %0d got %0d", $time, ex.x2, out_second_x);
        end
        if (out_second_y !== ex.y2) begin
          errors++;
          $display("%0t: second_y expected %0d got %0d", $time, ex.y2, out_second_y);
        end
      end
    end
  end

  task automatic send_query(query_t qi, bit typed, points_t pts);
    @(negedge clk);
    in_valid <= 1'b1;
    in_line_slope <= qi.slope;
    in_line_intercept <= qi.icpt;
    in_center_x <= qi.cx;
    in_center_y <= qi.cy;
    in_circle_radius <= qi.rad;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_points.push_back(typed ? pts : solve_crossing(qi));
  endtask

  task automatic pause_sender(int cycles);
    for (int i = 0; i < cycles; i++) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  initial begin
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_line_slope = 0;
    in_line_intercept = 0;
    in_center_x = 0;
    in_center_y = 0;
    in_circle_radius = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_query(directed[i].q, directed[i].typed, directed[i].pts);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
    end

    hold_request = 1'b1;
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        // The first bursts run without gaps so the hold-off fills the pipe.
        if (n > 300) pause_sender($urandom_range(0, 12));
        burst = $urandom_range(1, 40);
      end
      send_query(random_query(), 0, '{lci_pkg::CNT_NONE, 0, 0, 0, 0});
      burst--;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    $display("Checked %0d result beats: %0d tangent, %0d secant, rest with no crossing,",
             n_results, n_tangent, n_secant);
    $display("under bursty input, output stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
